### rtl/core/ecal_pkg.sv
// ----------------------------------------------------------------------------
// ecal_pkg
// Constants and the month-start table shared by the epoch-to-calendar pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package ecal_pkg;

  localparam int unsigned SecsW      = 31;
  localparam int unsigned DaysW      = 15;
  localparam int unsigned TodW       = 17;
  localparam int unsigned YearW      = 11;
  localparam int unsigned DoyW       = 9;

  // seconds -> days: secs / 86400 = (secs >> 7) / 675
  localparam int unsigned DayShift   = 7;
  localparam logic [24:0] DayRecip   = 25'd25451658;  // floor(2^34 / 675)
  localparam int unsigned DayRecipSh = 34;
  localparam logic [16:0] SecsPerDay = 17'd86400;

  // days counted from 1968-01-01, split into four-year blocks
  localparam logic [14:0] QuadOffset = 15'd731;
  localparam logic [15:0] QuadRecip  = 16'd45934;     // ceil(2^26 / 1461)
  localparam int unsigned QuadSh     = 26;
  localparam logic [10:0] DaysPerQuad = 11'd1461;
  localparam logic [10:0] YearBase   = 11'd1968;
  localparam logic [10:0] Yr1Start   = 11'd366;
  localparam logic [10:0] Yr2Start   = 11'd731;
  localparam logic [10:0] Yr3Start   = 11'd1096;

  // weekday: 1970-01-01 is a Thursday
  localparam logic [14:0] WeekOffset = 15'd3;
  localparam logic [15:0] WeekRecip  = 16'd37450;     // ceil(2^18 / 7)
  localparam int unsigned WeekSh     = 18;

  // time of day: hour = (tod >> 4) / 225, minute = (rem >> 2) / 15
  localparam logic [12:0] HourRecip  = 13'd4661;      // ceil(2^20 / 225)
  localparam int unsigned HourSh     = 20;
  localparam logic [11:0] SecsPerHour = 12'd3600;
  localparam logic [10:0] MinRecip   = 11'd1093;      // ceil(2^14 / 15)
  localparam int unsigned MinSh      = 14;
  localparam logic [5:0]  SecsPerMin = 6'd60;

  localparam int unsigned NumMonths  = 12;

  // day of year at which month idx (0 = January) starts
  function automatic logic [DoyW-1:0] month_start(input logic leap, input logic [3:0] idx);
    logic [DoyW-1:0] base;
    base = '0;
    unique case (idx)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd0;
    endcase
    if (leap && (idx >= 4'd2) && (idx < 4'd12)) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

endpackage

`default_nettype wire

### rtl/core/ecal_tod_split.sv
// ----------------------------------------------------------------------------
// ecal_tod_split
// Four-stage split of a second-of-day count into hour, minute and second.
// ----------------------------------------------------------------------------
`default_nettype none

module ecal_tod_split (
  input  wire logic                     clk_i,
  input  wire logic [3:0]               en_i,
  input  wire logic [ecal_pkg::TodW-1:0] tod_i,
  output logic      [4:0]               hour_o,
  output logic      [5:0]               minute_o,
  output logic      [5:0]               second_o
);
  import ecal_pkg::*;

  logic [TodW-1:0] tod4_q;
  logic [4:0]      hour4_q, hour5_q, hour6_q, hour7_q;
  logic [11:0]     rem5_q, rem6_q;
  logic [5:0]      min6_q, min7_q;
  logic [5:0]      sec7_q;

  logic [25:0] hour_prod;
  logic [16:0] hour_secs;
  logic [16:0] rem_full;
  logic [20:0] min_prod;
  logic [11:0] min_secs;
  logic [11:0] sec_full;

  always_comb begin
    hour_prod = tod_i[TodW-1:4] * HourRecip;
    hour_secs = hour4_q * SecsPerHour;
    rem_full  = tod4_q - hour_secs;
    min_prod  = rem5_q[11:2] * MinRecip;
    min_secs  = min6_q * SecsPerMin;
    sec_full  = rem6_q - min_secs;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      tod4_q  <= tod_i;
      hour4_q <= hour_prod[HourSh+4:HourSh];
    end
    if (en_i[1]) begin
      rem5_q  <= rem_full[11:0];
      hour5_q <= hour4_q;
    end
    if (en_i[2]) begin
      rem6_q  <= rem5_q;
      min6_q  <= min_prod[MinSh+5:MinSh];
      hour6_q <= hour5_q;
    end
    if (en_i[3]) begin
      sec7_q  <= sec_full[5:0];
      min7_q  <= min6_q;
      hour7_q <= hour6_q;
    end
  end

  assign hour_o   = hour7_q;
  assign minute_o = min7_q;
  assign second_o = sec7_q;

endmodule

`default_nettype wire

### rtl/core/epoch_seconds_to_calendar_unit.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_unit
// Seconds since 1970-01-01 00:00:00 to calendar date, time of day and weekday.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_ready_o carry one beat, epoch_seconds_i.
// Output channel: out_valid_o / out_ready_i carry one beat with year, month,
// day of month, hour, minute, second and weekday (1 Monday .. 7 Sunday).
// Every input beat gives exactly one output beat, in order.
// Pipeline: a beat passes from input to output valid through eight register
// stages (day split, correction, four-year block split, year in block,
// month search, day of month; time of day and weekday run alongside).
// Throughput: one beat per cycle while out_ready_i is high. Each stage holds
// its valid bit; it takes a new beat when empty or when its successor moves.
// Stall: when out_ready_i is low the output holds, and stages fill up behind
// it; in_ready_o drops only once all eight stages are full.
// Reset: rst_ni clears all valid bits; no beat is in flight afterwards.
// ----------------------------------------------------------------------------
`default_nettype none

module epoch_seconds_to_calendar_unit (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [ecal_pkg::SecsW-1:0] epoch_seconds_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic      [ecal_pkg::YearW-1:0] year_o,
  output logic      [3:0]                 month_o,
  output logic      [4:0]                 day_of_month_o,
  output logic      [4:0]                 hour_o,
  output logic      [5:0]                 minute_o,
  output logic      [5:0]                 second_o,
  output logic      [2:0]                 weekday_o
);
  import ecal_pkg::*;

  localparam int unsigned NumStages = 8;

  logic [NumStages:1] valid_q;
  logic [NumStages+1:1] en;

  // stage payload
  logic [SecsW-1:0] secs1_q;
  logic [DaysW-1:0] q1_q, q2_q;
  logic [17:0]      rem2_q;
  logic [DaysW-1:0] days3_q;
  logic [TodW-1:0]  tod3_q;
  logic [DaysW-1:0] dp4_q, wsum4_q;
  logic [4:0]       quad4_q;
  logic [12:0]      wq4_q;
  logic [10:0]      r5_q;
  logic [4:0]       quad5_q;
  logic [2:0]       wd5_q, wd6_q, wd7_q, wd8_q;
  logic [YearW-1:0] year6_q, year7_q, year8_q;
  logic [DoyW-1:0]  doy6_q, doy7_q;
  logic             leap6_q, leap7_q;
  logic [3:0]       mi7_q, month8_q;
  logic [4:0]       dom8_q;
  logic [4:0]       hour8_q;
  logic [5:0]       min8_q, sec8_q;

  logic [4:0] tod_hour;
  logic [5:0] tod_min, tod_sec;

  // stage logic
  logic [48:0]      day_prod;
  logic [31:0]      day_secs;
  logic [31:0]      rem_full;
  logic [17:0]      rem_corr;
  logic [DaysW-1:0] dp_d;
  logic [30:0]      quad_prod;
  logic [DaysW-1:0] wsum_d;
  logic [30:0]      week_prod;
  logic [15:0]      quad_days;
  logic [15:0]      r_full;
  logic [15:0]      wq7;
  logic [15:0]      w_full;
  logic [1:0]       yi;
  logic [10:0]      yr_start;
  logic [10:0]      doy_full;
  logic [3:0]       mi_d;
  logic [DoyW-1:0]  dom_base;
  logic [DoyW-1:0]  dom_full;

  always_comb begin
    en[NumStages+1] = out_ready_i;
    for (int s = NumStages; s >= 1; s--) begin
      en[s] = !valid_q[s] || en[s+1];
    end
  end

  assign in_ready_o = en[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[1]) begin
        valid_q[1] <= in_valid_i;
      end
      for (int s = 2; s <= NumStages; s++) begin
        if (en[s]) begin
          valid_q[s] <= valid_q[s-1];
        end
      end
    end
  end

  always_comb begin
    day_prod  = epoch_seconds_i[SecsW-1:DayShift] * DayRecip;
    day_secs  = q1_q * SecsPerDay;
    rem_full  = {1'b0, secs1_q} - day_secs;
    rem_corr  = rem2_q - {1'b0, SecsPerDay};
    dp_d      = days3_q + QuadOffset;
    quad_prod = dp_d * QuadRecip;
    wsum_d    = days3_q + WeekOffset;
    week_prod = wsum_d * WeekRecip;
    quad_days = quad4_q * DaysPerQuad;
    r_full    = {1'b0, dp4_q} - quad_days;
    wq7       = {wq4_q, 3'b000} - {3'b000, wq4_q};
    w_full    = {1'b0, wsum4_q} - wq7;
    if (r5_q < Yr1Start) begin
      yi       = 2'd0;
      yr_start = 11'd0;
    end else if (r5_q < Yr2Start) begin
      yi       = 2'd1;
      yr_start = Yr1Start;
    end else if (r5_q < Yr3Start) begin
      yi       = 2'd2;
      yr_start = Yr2Start;
    end else begin
      yi       = 2'd3;
      yr_start = Yr3Start;
    end
    doy_full = r5_q - yr_start;
    mi_d = '0;
    for (int k = 1; k < NumMonths; k++) begin
      mi_d = mi_d + 4'(doy6_q >= month_start(leap6_q, 4'(k)));
    end
    dom_base = month_start(leap7_q, mi7_q);
    dom_full = doy7_q - dom_base + 9'd1;
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      secs1_q <= epoch_seconds_i;
      q1_q    <= day_prod[DayRecipSh+DaysW-1:DayRecipSh];
    end
    if (en[2]) begin
      q2_q   <= q1_q;
      rem2_q <= rem_full[17:0];
    end
    if (en[3]) begin
      if (rem2_q >= {1'b0, SecsPerDay}) begin
        days3_q <= q2_q + 15'd1;
        tod3_q  <= rem_corr[TodW-1:0];
      end else begin
        days3_q <= q2_q;
        tod3_q  <= rem2_q[TodW-1:0];
      end
    end
    if (en[4]) begin
      dp4_q   <= dp_d;
      quad4_q <= quad_prod[QuadSh+4:QuadSh];
      wsum4_q <= wsum_d;
      wq4_q   <= week_prod[WeekSh+12:WeekSh];
    end
    if (en[5]) begin
      r5_q    <= r_full[10:0];
      quad5_q <= quad4_q;
      wd5_q   <= w_full[2:0] + 3'd1;
    end
    if (en[6]) begin
      year6_q <= YearBase + {4'b0000, quad5_q, 2'b00} + {9'd0, yi};
      doy6_q  <= doy_full[DoyW-1:0];
      leap6_q <= (yi == 2'd0);
      wd6_q   <= wd5_q;
    end
    if (en[7]) begin
      year7_q <= year6_q;
      doy7_q  <= doy6_q;
      leap7_q <= leap6_q;
      mi7_q   <= mi_d;
      wd7_q   <= wd6_q;
    end
    if (en[8]) begin
      year8_q  <= year7_q;
      month8_q <= mi7_q + 4'd1;
      dom8_q   <= dom_full[4:0];
      wd8_q    <= wd7_q;
      hour8_q  <= tod_hour;
      min8_q   <= tod_min;
      sec8_q   <= tod_sec;
    end
  end

  ecal_tod_split u_tod_split (
    .clk_i    (clk_i),
    .en_i     (en[7:4]),
    .tod_i    (tod3_q),
    .hour_o   (tod_hour),
    .minute_o (tod_min),
    .second_o (tod_sec)
  );

  assign out_valid_o    = valid_q[NumStages];
  assign year_o         = year8_q;
  assign month_o        = month8_q;
  assign day_of_month_o = dom8_q;
  assign hour_o         = hour8_q;
  assign minute_o       = min8_q;
  assign second_o       = sec8_q;
  assign weekday_o      = wd8_q;

endmodule

`default_nettype wire
